@@ hdl/jfc_pkg.sv @@
package jfc_pkg;

    localparam int DEPTH     = 16;
    localparam int ID_BITS   = 16;
    localparam int TYPE_BITS = 2;
    localparam int SLOT_BITS = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [CNT_BITS-1:0]  count_t;
    typedef logic [ID_BITS-1:0]   job_id_t;
    typedef logic [TYPE_BITS-1:0] job_type_t;

    // command codes
    typedef enum logic [1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_CANCEL = 2'd2,
        CMD_LIST   = 2'd3
    } cmd_t;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // write requests to the entry store
    typedef struct packed {
        logic      data_we;
        slot_t     data_addr;
        job_id_t   id;
        job_type_t jtype;
        logic      link_we;
        slot_t     link_addr;
        slot_t     link_val;
    } store_wr_t;

    // lowest slot whose used bit is clear
    function automatic slot_t first_free(input logic [DEPTH-1:0] used);
        slot_t idx;
        idx = '0;
        for (int k = DEPTH - 1; k >= 0; k--)
        begin
            if (!used[k])
            begin
                idx = slot_t'(k);
            end
        end
        return idx;
    endfunction

endpackage

@@ hdl/job_fifo_with_cancel.sv @@
// enqueue, and any command on an empty queue, shows its result in the cycle after accept
// dequeue: the head entry is read through the store's read registers, then the result is registered;
// cancel and list walk the linked entries one per cycle from the head, through the linked reads
// on the single read port of the entry store; busy stays high until the final result
// throughput: one enqueue per cycle; the receiver cannot stall, results are strobed by done
// reset: asynchronous, clears the used map, head, tail and count; entry memories are not cleared
module job_fifo_with_cancel (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    cmd,
    input  logic [jfc_pkg::ID_BITS-1:0]   job_id,
    input  logic [jfc_pkg::TYPE_BITS-1:0] job_kind,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [jfc_pkg::ID_BITS-1:0]   out_job_id,
    output logic [jfc_pkg::TYPE_BITS-1:0] out_job_type,
    output logic                          last
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } state_t;

    state_t                     state_reg, state_next;
    logic [jfc_pkg::DEPTH-1:0]  used_reg, used_next;
    jfc_pkg::slot_t             head_reg, head_next;
    jfc_pkg::slot_t             tail_reg, tail_next;
    jfc_pkg::count_t            count_reg, count_next;
    logic                       done_reg, done_next;

    jfc_pkg::cmd_t              cmd_reg, cmd_next;
    jfc_pkg::job_id_t           id_reg, id_next;
    jfc_pkg::slot_t             cur_reg, cur_next;
    jfc_pkg::slot_t             prev_reg, prev_next;
    jfc_pkg::slot_t             step_reg, step_next;
    logic [1:0]                 status_reg, status_next;
    jfc_pkg::job_id_t           oid_reg, oid_next;
    jfc_pkg::job_type_t         otype_reg, otype_next;
    logic                       last_reg, last_next;

    jfc_pkg::slot_t             rd_addr;
    jfc_pkg::store_wr_t         wr;
    jfc_pkg::job_id_t           rd_id;
    jfc_pkg::job_type_t         rd_type;
    jfc_pkg::slot_t             rd_link;
    jfc_pkg::slot_t             free_slot;
    logic                       last_step;

    jfc_store u_store (
        .clk     (clk),
        .rd_addr (rd_addr),
        .wr      (wr),
        .rd_id   (rd_id),
        .rd_type (rd_type),
        .rd_link (rd_link)
    );

    assign free_slot = jfc_pkg::first_free(used_reg);
    assign last_step = (jfc_pkg::count_t'(step_reg) + jfc_pkg::count_t'(1)) == count_reg;

    // read address follows the head when idle, the fetched link while walking
    assign rd_addr = (state_reg == S_IDLE) ? head_reg : rd_link;

    // command sequencer
    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        cmd_next    = cmd_reg;
        id_next     = id_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        status_next = jfc_pkg::ST_OK;
        oid_next    = '0;
        otype_next  = '0;
        last_next   = 1'b1;
        wr          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = jfc_pkg::cmd_t'(cmd);
                    id_next   = job_id;
                    cur_next  = head_reg;
                    prev_next = head_reg;
                    step_next = '0;
                    unique case (jfc_pkg::cmd_t'(cmd))
                        jfc_pkg::CMD_ENQ:
                        begin
                            done_next = 1'b1;
                            if (count_reg == jfc_pkg::count_t'(jfc_pkg::DEPTH))
                            begin
                                status_next = jfc_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr.data_we   = 1'b1;
                                wr.data_addr = free_slot;
                                wr.id        = job_id;
                                wr.jtype     = job_kind;
                                wr.link_we   = (count_reg != '0);
                                wr.link_addr = tail_reg;
                                wr.link_val  = free_slot;
                                used_next    = used_reg
                                             | (jfc_pkg::DEPTH'(1) << free_slot);
                                if (count_reg == '0)
                                begin
                                    head_next = free_slot;
                                end
                                tail_next  = free_slot;
                                count_next = count_reg + jfc_pkg::count_t'(1);
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = (jfc_pkg::cmd_t'(cmd) == jfc_pkg::CMD_CANCEL)
                                            ? jfc_pkg::ST_NOTFOUND : jfc_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                unique case (cmd_reg)
                    jfc_pkg::CMD_DEQ:
                    begin
                        done_next  = 1'b1;
                        oid_next   = rd_id;
                        otype_next = rd_type;
                        used_next  = used_reg & ~(jfc_pkg::DEPTH'(1) << cur_reg);
                        count_next = count_reg - jfc_pkg::count_t'(1);
                        if (count_reg == jfc_pkg::count_t'(1))
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        else
                        begin
                            head_next = rd_link;
                        end
                        state_next = S_IDLE;
                    end

                    jfc_pkg::CMD_LIST:
                    begin
                        done_next  = 1'b1;
                        oid_next   = rd_id;
                        otype_next = rd_type;
                        last_next  = last_step;
                        if (last_step)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cur_next  = rd_link;
                            step_next = step_reg + jfc_pkg::slot_t'(1);
                        end
                    end

                    jfc_pkg::CMD_CANCEL:
                    begin
                        if (rd_id == id_reg)
                        begin
                            // unlink the matching entry
                            done_next = 1'b1;
                            if (step_reg == '0)
                            begin
                                head_next = rd_link;
                            end
                            else
                            begin
                                wr.link_we   = 1'b1;
                                wr.link_addr = prev_reg;
                                wr.link_val  = rd_link;
                            end
                            if (last_step)
                            begin
                                tail_next = prev_reg;
                            end
                            used_next  = used_reg & ~(jfc_pkg::DEPTH'(1) << cur_reg);
                            count_next = count_reg - jfc_pkg::count_t'(1);
                            if (count_reg == jfc_pkg::count_t'(1))
                            begin
                                head_next = '0;
                                tail_next = '0;
                            end
                            state_next = S_IDLE;
                        end
                        else if (last_step)
                        begin
                            done_next   = 1'b1;
                            status_next = jfc_pkg::ST_NOTFOUND;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            prev_next = cur_reg;
                            cur_next  = rd_link;
                            step_next = step_reg + jfc_pkg::slot_t'(1);
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // transaction and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        id_reg     <= id_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        step_reg   <= step_next;
        status_reg <= status_next;
        oid_reg    <= oid_next;
        otype_reg  <= otype_next;
        last_reg   <= last_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign out_job_id   = oid_reg;
    assign out_job_type = otype_reg;
    assign last         = last_reg;

endmodule

@@ hdl/jfc_store.sv @@
module jfc_store (
    input  logic                clk,
    input  jfc_pkg::slot_t      rd_addr,
    input  jfc_pkg::store_wr_t  wr,
    output jfc_pkg::job_id_t    rd_id,
    output jfc_pkg::job_type_t  rd_type,
    output jfc_pkg::slot_t      rd_link
);

    // entry payload and link memories, one write and one read port each
    logic [jfc_pkg::ID_BITS+jfc_pkg::TYPE_BITS-1:0] data_mem [jfc_pkg::DEPTH];
    jfc_pkg::slot_t                                 link_mem [jfc_pkg::DEPTH];

    logic [jfc_pkg::ID_BITS+jfc_pkg::TYPE_BITS-1:0] data_rd_reg;
    jfc_pkg::slot_t                                 link_rd_reg;

    // payload memory
    always_ff @(posedge clk)
    begin
        if (wr.data_we)
        begin
            data_mem[wr.data_addr] <= {wr.id, wr.jtype};
        end
        data_rd_reg <= data_mem[rd_addr];
    end

    // link memory
    always_ff @(posedge clk)
    begin
        if (wr.link_we)
        begin
            link_mem[wr.link_addr] <= wr.link_val;
        end
        link_rd_reg <= link_mem[rd_addr];
    end

    assign rd_id   = data_rd_reg[jfc_pkg::ID_BITS+jfc_pkg::TYPE_BITS-1:jfc_pkg::TYPE_BITS];
    assign rd_type = data_rd_reg[jfc_pkg::TYPE_BITS-1:0];
    assign rd_link = link_rd_reg;

endmodule

@@ hdl/jfc_checker.sv @@
module jfc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [1:0]                    cmd,
    input logic                          done,
    input logic [1:0]                    status,
    input logic [jfc_pkg::ID_BITS-1:0]   out_job_id,
    input logic [jfc_pkg::TYPE_BITS-1:0] out_job_type,
    input logic                          last
);

    // an enqueue is answered in the next cycle with a single result
    a_enq_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd == jfc_pkg::CMD_ENQ) |=> done && last)
        else $error("enqueue result missing");

    // any result other than ok is the only result of its transaction
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != jfc_pkg::ST_OK) |-> last)
        else $error("error result not marked last");

    // error results, which carry no entry, report zero id and type
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != jfc_pkg::ST_OK) |-> (out_job_id == '0) && (out_job_type == '0))
        else $error("error result carries payload");

    // a list streams without gaps
    a_list_stream: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |=> done)
        else $error("gap inside a list");

    // the block is ready again once the final result shows
    a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
        done && last |-> !busy)
        else $error("busy after final result");

endmodule

bind job_fifo_with_cancel jfc_checker u_jfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .done         (done),
    .status       (status),
    .out_job_id   (out_job_id),
    .out_job_type (out_job_type),
    .last         (last)
);
